>>> src/re8_pkg.sv
package re8_pkg;

	localparam int DIMS    = 8;
	localparam int IN_W    = 20;
	localparam int OUT_W   = 13;
	localparam int FRAC    = 8;
	localparam int ONE_FIX = 1 << FRAC;
	localparam int CV_W    = IN_W + 1;
	localparam int ACC_W   = CV_W + 1;
	localparam int RSH     = FRAC + 1;
	localparam int DERR_W  = FRAC + 2;
	localparam int TERR_W  = FRAC + 3;
	localparam int SQ_W    = 2 * (FRAC + 1) + 1;
	localparam int ESUM_W  = SQ_W + $clog2(DIMS);
	localparam int IDX_W   = $clog2(DIMS);
	localparam int S_DW    = DIMS * IN_W;
	localparam int M_DW    = ((DIMS * OUT_W + 7) / 8) * 8;

	typedef logic signed [CV_W-1:0]   cval_t;
	typedef logic signed [OUT_W-1:0]  pt_t;
	typedef logic signed [DERR_W-1:0] derr_t;
	typedef logic signed [TERR_W-1:0] terr_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [ESUM_W-1:0]        esum_t;

	typedef cval_t cvec_t [DIMS];
	typedef pt_t   pvec_t [DIMS];
	typedef derr_t dvec_t [DIMS];
	typedef terr_t tvec_t [DIMS];
	typedef sq_t   sqvec_t [DIMS];

endpackage

>>> src/re8_coset_round.sv
module re8_coset_round import re8_pkg::*; (
	input  cvec_t v,
	output pvec_t y,
	output dvec_t d,
	output logic  odd
);

	logic signed [ACC_W-1:0] acc [DIMS];
	logic signed [ACC_W-1:0] rnd [DIMS];

	// nearest even integer, ties away from zero: q = floor((v + 256 - neg) / 512)
	always_comb begin
		odd = 1'b0;
		for (int i = 0; i < DIMS; i++) begin
			rnd[i] = v[i][CV_W-1] ? ACC_W'(ONE_FIX - 1) : ACC_W'(ONE_FIX);
			acc[i] = ACC_W'(v[i]) + rnd[i];
			y[i]   = {acc[i][RSH+OUT_W-2:RSH], 1'b0};
			d[i]   = derr_t'({1'b0, acc[i][RSH-1:0]}) - derr_t'(rnd[i]);
			odd    = odd ^ acc[i][RSH];
		end
	end

endmodule

>>> src/re8_parity_fix.sv
module re8_parity_fix import re8_pkg::*; (
	input  pvec_t y,
	input  dvec_t d,
	input  logic  odd,
	output pvec_t yo,
	output tvec_t t
);

	logic [DERR_W-2:0] best;
	logic [DERR_W-2:0] mag [DIMS];
	logic [IDX_W-1:0]  pick;

	// when the parity is odd, the first coordinate of largest error moves by 2 toward the input
	always_comb begin
		best = '0;
		pick = '0;
		for (int i = 0; i < DIMS; i++) begin
			mag[i] = d[i][DERR_W-1] ? (DERR_W-1)'(-d[i]) : (DERR_W-1)'(d[i]);
			if (mag[i] > best) begin
				best = mag[i];
				pick = IDX_W'(i);
			end
		end
		for (int i = 0; i < DIMS; i++) begin
			yo[i] = y[i];
			t[i]  = TERR_W'(d[i]);
		end
		if (odd) begin
			if (d[pick][DERR_W-1]) begin
				yo[pick] = y[pick] - pt_t'(2);
				t[pick]  = TERR_W'(d[pick]) + terr_t'(2 * ONE_FIX);
			end else begin
				yo[pick] = y[pick] + pt_t'(2);
				t[pick]  = TERR_W'(d[pick]) - terr_t'(2 * ONE_FIX);
			end
		end
	end

endmodule

>>> src/re8_lattice_nearest_point.sv
// Nearest RE8 (Gosset) lattice point to an 8-vector of signed Q11.8 coordinates.
// Five-stage pipeline: coset rounding, parity fix, squared errors, error sums,
// coset select. One vector is taken every cycle while the output side does not stall;
// each result is registered in every stage before it reaches the output.
// Backpressure stalls only the stages that hold data, so bubbles are squeezed out.
// On equal squared error the odd coset (2D8 + 1) is returned.
module re8_lattice_nearest_point import re8_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [S_DW-1:0] s_tdata,  // coord_0 .. coord_7, 20 bits each
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [M_DW-1:0] m_tdata   // point_0 .. point_7, 13 bits each
);

	cvec_t  v_in, vs_in;
	pvec_t  y1_r, y2_r, y1_f, y2_f;
	dvec_t  d1_r, d2_r;
	logic   odd1_r, odd2_r;
	tvec_t  t1_f, t2_f;
	sqvec_t sq1_c, sq2_c;
	terr_t  ta1, ta2;
	esum_t  e1_c, e2_c;

	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic   rdy1, rdy2, rdy3, rdy4, rdy5;

	pvec_t  y1_s1, y2_s1;
	dvec_t  d1_s1, d2_s1;
	logic   odd1_s1, odd2_s1;
	pvec_t  y1_s2, y2_s2;
	tvec_t  t1_s2, t2_s2;
	pvec_t  y1_s3, y2_s3;
	sqvec_t sq1_s3, sq2_s3;
	pvec_t  y1_s4, y2_s4;
	esum_t  e1_s4, e2_s4;
	pvec_t  pt_s5;

	always_comb begin
		for (int i = 0; i < DIMS; i++) begin
			v_in[i]  = CV_W'($signed(s_tdata[i*IN_W +: IN_W]));
			vs_in[i] = v_in[i] - cval_t'(ONE_FIX);
		end
	end

	re8_coset_round u_round_even (.v(v_in),  .y(y1_r), .d(d1_r), .odd(odd1_r));
	re8_coset_round u_round_odd  (.v(vs_in), .y(y2_r), .d(d2_r), .odd(odd2_r));

	re8_parity_fix u_fix_even (.y(y1_s1), .d(d1_s1), .odd(odd1_s1), .yo(y1_f), .t(t1_f));
	re8_parity_fix u_fix_odd  (.y(y2_s1), .d(d2_s1), .odd(odd2_s1), .yo(y2_f), .t(t2_f));

	always_comb begin
		e1_c = '0;
		e2_c = '0;
		for (int i = 0; i < DIMS; i++) begin
			ta1      = t1_s2[i][TERR_W-1] ? -t1_s2[i] : t1_s2[i];
			ta2      = t2_s2[i][TERR_W-1] ? -t2_s2[i] : t2_s2[i];
			sq1_c[i] = SQ_W'($unsigned(ta1)) * SQ_W'($unsigned(ta1));
			sq2_c[i] = SQ_W'($unsigned(ta2)) * SQ_W'($unsigned(ta2));
			e1_c     = e1_c + ESUM_W'(sq1_s3[i]);
			e2_c     = e2_c + ESUM_W'(sq2_s3[i]);
		end
	end

	assign rdy5     = !vld_s5 || m_tready;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			y1_s1   <= y1_r;
			y2_s1   <= y2_r;
			d1_s1   <= d1_r;
			d2_s1   <= d2_r;
			odd1_s1 <= odd1_r;
			odd2_s1 <= odd2_r;
		end
		if (rdy2 && vld_s1) begin
			y1_s2 <= y1_f;
			y2_s2 <= y2_f;
			t1_s2 <= t1_f;
			t2_s2 <= t2_f;
		end
		if (rdy3 && vld_s2) begin
			y1_s3  <= y1_s2;
			y2_s3  <= y2_s2;
			sq1_s3 <= sq1_c;
			sq2_s3 <= sq2_c;
		end
		if (rdy4 && vld_s3) begin
			y1_s4 <= y1_s3;
			y2_s4 <= y2_s3;
			e1_s4 <= e1_c;
			e2_s4 <= e2_c;
		end
		if (rdy5 && vld_s4) begin
			for (int i = 0; i < DIMS; i++) begin
				pt_s5[i] <= (e1_s4 < e2_s4) ? y1_s4[i] : (y2_s4[i] | pt_t'(1));
			end
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < DIMS; i++) begin
			m_tdata[i*OUT_W +: OUT_W] = pt_s5[i];
		end
	end

endmodule
